// File: rtl/ramc_pkg.sv
// ----------------------------------------------------------------------------
// Rational unit package
// Shared widths, command codes and sequencer encodings for the rational
// add, multiply and compare unit.
// ----------------------------------------------------------------------------
package ramc_pkg;

    // Word geometry.
    localparam int WORD_BITS = 64;
    localparam int DEN_BITS  = WORD_BITS - 1;
    localparam int WIDE_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(WIDE_BITS) + 1;
    localparam int SHF_BITS  = $clog2(WORD_BITS) + 1;

    // Command codes.
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_LT  = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    // Top-level control states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_GCD
    } t_state;

    // Sequencer program steps.
    typedef enum logic [4:0] {
        P_DEC,
        P_CMP1, P_CMP2,
        P_RA1, P_RA2, P_RA3,
        P_RB1, P_RB2, P_RB3,
        P_M1, P_M2, P_M3, P_M4, P_M5, P_M6, P_M7, P_M8,
        P_A1, P_A2, P_A3, P_A4, P_A5, P_A6, P_A7, P_A8, P_A9, P_A10, P_A11,
        P_FIN
    } t_pc;

endpackage

// File: rtl/rational_add_mul_compare_unit.sv
// ----------------------------------------------------------------------------
// Rational add, multiply and compare unit
// Takes two 64-bit rationals and a command word, and returns the reduced sum
// or product, or a less-than flag, using one serial divider, one shift-add
// multiplier and one binary gcd engine under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake         | Words
//  --------+-------------------+--------------------------------------------
//  input   | start, busy       | i_cmd, i_num_a, i_den_a, i_num_b, i_den_b
//  result  | o_done (strobe)   | o_result_num, o_result_den, o_is_less,
//          |                   | o_overflow
//
// A word is taken when start is high and busy is low; busy stays high until
// the result strobe. A compare runs two products in the shift-add multiplier;
// an add or multiply runs a chain of divides in the bit-serial divider,
// products in the shift-add multiplier and gcds in the binary gcd engine.
// Reset is synchronous and active low; it clears the sequencer and the strobe.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module rational_add_mul_compare_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_cmd,
    input  logic signed [ramc_pkg::WORD_BITS-1:0] i_num_a,
    input  logic [ramc_pkg::DEN_BITS-1:0] i_den_a,
    input  logic signed [ramc_pkg::WORD_BITS-1:0] i_num_b,
    input  logic [ramc_pkg::DEN_BITS-1:0] i_den_b,
    output logic                         o_done,
    output logic signed [ramc_pkg::WORD_BITS-1:0] o_result_num,
    output logic [ramc_pkg::DEN_BITS-1:0] o_result_den,
    output logic                         o_is_less,
    output logic                         o_overflow
);

    localparam int W  = ramc_pkg::WORD_BITS;
    localparam int WW = ramc_pkg::WIDE_BITS;
    localparam int CB = ramc_pkg::CNT_BITS;
    localparam int SB = ramc_pkg::SHF_BITS;

    ramc_pkg::t_state r_state, n_state;
    ramc_pkg::t_pc    r_pc, n_pc, r_gret, n_gret;

    logic [CB-1:0] r_cnt, n_cnt;
    logic [1:0]    r_cmd, n_cmd;
    logic          r_sa, n_sa, r_sb, n_sb;
    logic [W-1:0]  r_ma, n_ma, r_mb, n_mb, r_da, n_da, r_db, n_db;
    logic [W-1:0]  r_g, n_g, r_g1, n_g1, r_g2, n_g2, r_t1, n_t1;
    logic [WW-1:0] r_x, n_x, r_rn, n_rn, r_rd, n_rd;
    logic          r_neg, n_neg, r_less, n_less, r_ovf, n_ovf;
    logic [WW-1:0] r_dq, n_dq;
    logic [W-1:0]  r_dd, n_dd, r_rem, n_rem;
    logic [WW-1:0] r_p, n_p;
    logic [W-1:0]  r_mc, n_mc;
    logic [W-1:0]  r_ga, n_ga, r_gb, n_gb;
    logic [SB-1:0] r_gk, n_gk;
    logic          r_done, n_done;
    logic [W-1:0]  r_onum, n_onum;
    logic [W-2:0]  r_oden, n_oden;
    logic          r_oless, n_oless, r_oovf, n_oovf;

    // Unit launch requests raised by the program steps.
    logic          div_go, mul_go, gcd_go;
    logic [WW-1:0] div_n;
    logic [W-1:0]  div_d, mul_a, mul_b, gcd_a, gcd_b;
    ramc_pkg::t_pc step_pc, gcd_ret;

    // Datapath of the shared units.
    logic [W:0]    div_t;
    logic          div_fit;
    logic [W:0]    mul_s;
    logic [WW-1:0] add_n;
    logic          add_neg;
    logic [WW-1:0] neg_p;
    logic          fits_ok;

    assign div_t   = {r_rem, r_dq[WW-1]};
    assign div_fit = div_t >= {1'b0, r_dd};
    assign mul_s   = {1'b0, r_p[WW-1:W]} + (r_p[0] ? {1'b0, r_mc} : {(W+1){1'b0}});
    assign neg_p   = ~r_p + {{(WW-1){1'b0}}, 1'b1};
    assign fits_ok = (r_rn[WW-1:W-1] == '0) && (r_rd[WW-1:W-1] == '0);

    // Signed sum of the two cross products for the add command.
    always_comb begin
        if (r_sa == r_sb) begin
            add_n   = r_x + r_p;
            add_neg = r_sa;
        end else if (r_x >= r_p) begin
            add_n   = r_x - r_p;
            add_neg = r_sa;
        end else begin
            add_n   = r_p - r_x;
            add_neg = r_sb;
        end
    end

    // Sequencer: next state, program steps and the unit iterations.
    always_comb begin
        n_state = r_state;  n_pc = r_pc;    n_gret = r_gret;  n_cnt = r_cnt;
        n_cmd = r_cmd;      n_sa = r_sa;    n_sb = r_sb;
        n_ma = r_ma;        n_mb = r_mb;    n_da = r_da;      n_db = r_db;
        n_g = r_g;          n_g1 = r_g1;    n_g2 = r_g2;      n_t1 = r_t1;
        n_x = r_x;          n_rn = r_rn;    n_rd = r_rd;
        n_neg = r_neg;      n_less = r_less; n_ovf = r_ovf;
        n_dq = r_dq;        n_dd = r_dd;    n_rem = r_rem;
        n_p = r_p;          n_mc = r_mc;
        n_ga = r_ga;        n_gb = r_gb;    n_gk = r_gk;
        n_done = 1'b0;
        n_onum = r_onum;    n_oden = r_oden; n_oless = r_oless; n_oovf = r_oovf;
        div_go = 1'b0;      div_n = '0;     div_d = '0;
        mul_go = 1'b0;      mul_a = '0;     mul_b = '0;
        gcd_go = 1'b0;      gcd_a = '0;     gcd_b = '0;
        gcd_ret = ramc_pkg::P_FIN;
        step_pc = ramc_pkg::P_FIN;

        case (r_state)
            ramc_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_sa    = i_num_a[W-1];
                    n_sb    = i_num_b[W-1];
                    n_ma    = i_num_a[W-1] ? (~i_num_a + 1'b1) : i_num_a;
                    n_mb    = i_num_b[W-1] ? (~i_num_b + 1'b1) : i_num_b;
                    n_da    = {1'b0, i_den_a};
                    n_db    = {1'b0, i_den_b};
                    n_state = ramc_pkg::S_EXEC;
                    n_pc    = ramc_pkg::P_DEC;
                end
            end

            ramc_pkg::S_DIV: begin
                // One restoring divide step per cycle.
                n_rem = div_fit ? (div_t[W-1:0] - r_dd) : div_t[W-1:0];
                n_dq  = {r_dq[WW-2:0], div_fit};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == {{(CB-1){1'b0}}, 1'b1}) begin
                    n_state = ramc_pkg::S_EXEC;
                end
            end

            ramc_pkg::S_MUL: begin
                // One shift-add step per cycle.
                n_p   = {mul_s, r_p[W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == {{(CB-1){1'b0}}, 1'b1}) begin
                    n_state = ramc_pkg::S_EXEC;
                end
            end

            ramc_pkg::S_GCD: begin
                // Binary gcd: one halving or subtraction per cycle.
                if (r_ga == '0 || r_gb == '0) begin
                    n_ga    = (r_ga | r_gb) << r_gk;
                    n_state = ramc_pkg::S_EXEC;
                    n_pc    = r_gret;
                end else if (!r_ga[0] && !r_gb[0]) begin
                    n_ga = r_ga >> 1;
                    n_gb = r_gb >> 1;
                    n_gk = r_gk + 1'b1;
                end else if (!r_ga[0]) begin
                    n_ga = r_ga >> 1;
                end else if (!r_gb[0]) begin
                    n_gb = r_gb >> 1;
                end else if (r_ga >= r_gb) begin
                    n_ga = r_ga - r_gb;
                end else begin
                    n_gb = r_gb - r_ga;
                end
            end

            ramc_pkg::S_EXEC: begin
                case (r_pc)
                    ramc_pkg::P_DEC: begin
                        n_rn = '0;  n_rd = {{(WW-1){1'b0}}, 1'b1};
                        n_neg = 1'b0; n_less = 1'b0; n_ovf = 1'b0;
                        if (r_cmd == ramc_pkg::CMD_NOP) begin
                            n_pc = ramc_pkg::P_FIN;
                        end else if (r_da == '0 || r_db == '0) begin
                            n_ovf = 1'b1;
                            n_pc  = ramc_pkg::P_FIN;
                        end else if (r_cmd == ramc_pkg::CMD_LT) begin
                            mul_go = 1'b1; mul_a = r_ma; mul_b = r_db;
                            step_pc = ramc_pkg::P_CMP1;
                        end else begin
                            gcd_go = 1'b1; gcd_a = r_ma; gcd_b = r_da;
                            gcd_ret = ramc_pkg::P_RA1;
                        end
                    end
                    ramc_pkg::P_CMP1: begin
                        n_x = r_sa ? neg_p : r_p;
                        mul_go = 1'b1; mul_a = r_mb; mul_b = r_da;
                        step_pc = ramc_pkg::P_CMP2;
                    end
                    ramc_pkg::P_CMP2: begin
                        n_less = $signed(r_x) < $signed(r_sb ? neg_p : r_p);
                        n_pc   = ramc_pkg::P_FIN;
                    end
                    // Reduce the first operand.
                    ramc_pkg::P_RA1: begin
                        n_g = r_ga;
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_ma}; div_d = r_ga;
                        step_pc = ramc_pkg::P_RA2;
                    end
                    ramc_pkg::P_RA2: begin
                        n_ma = r_dq[W-1:0];
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_da}; div_d = r_g;
                        step_pc = ramc_pkg::P_RA3;
                    end
                    ramc_pkg::P_RA3: begin
                        n_da = r_dq[W-1:0];
                        gcd_go = 1'b1; gcd_a = r_mb; gcd_b = r_db;
                        gcd_ret = ramc_pkg::P_RB1;
                    end
                    // Reduce the second operand.
                    ramc_pkg::P_RB1: begin
                        n_g = r_ga;
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_mb}; div_d = r_ga;
                        step_pc = ramc_pkg::P_RB2;
                    end
                    ramc_pkg::P_RB2: begin
                        n_mb = r_dq[W-1:0];
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_db}; div_d = r_g;
                        step_pc = ramc_pkg::P_RB3;
                    end
                    ramc_pkg::P_RB3: begin
                        n_db = r_dq[W-1:0];
                        if (r_cmd == ramc_pkg::CMD_MUL) begin
                            if (r_ma == '0 || r_mb == '0) begin
                                n_pc = ramc_pkg::P_FIN;
                            end else begin
                                gcd_go = 1'b1; gcd_a = r_ma; gcd_b = r_dq[W-1:0];
                                gcd_ret = ramc_pkg::P_M1;
                            end
                        end else begin
                            gcd_go = 1'b1; gcd_a = r_da; gcd_b = r_dq[W-1:0];
                            gcd_ret = ramc_pkg::P_A1;
                        end
                    end
                    // Multiply: cancel the cross gcds, then multiply.
                    ramc_pkg::P_M1: begin
                        n_g1 = r_ga;
                        gcd_go = 1'b1; gcd_a = r_mb; gcd_b = r_da;
                        gcd_ret = ramc_pkg::P_M2;
                    end
                    ramc_pkg::P_M2: begin
                        n_g2 = r_ga;
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_ma}; div_d = r_g1;
                        step_pc = ramc_pkg::P_M3;
                    end
                    ramc_pkg::P_M3: begin
                        n_t1 = r_dq[W-1:0];
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_mb}; div_d = r_g2;
                        step_pc = ramc_pkg::P_M4;
                    end
                    ramc_pkg::P_M4: begin
                        mul_go = 1'b1; mul_a = r_t1; mul_b = r_dq[W-1:0];
                        step_pc = ramc_pkg::P_M5;
                    end
                    ramc_pkg::P_M5: begin
                        n_rn = r_p;
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_da}; div_d = r_g2;
                        step_pc = ramc_pkg::P_M6;
                    end
                    ramc_pkg::P_M6: begin
                        n_t1 = r_dq[W-1:0];
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_db}; div_d = r_g1;
                        step_pc = ramc_pkg::P_M7;
                    end
                    ramc_pkg::P_M7: begin
                        mul_go = 1'b1; mul_a = r_t1; mul_b = r_dq[W-1:0];
                        step_pc = ramc_pkg::P_M8;
                    end
                    ramc_pkg::P_M8: begin
                        n_rd  = r_p;
                        n_neg = r_sa != r_sb;
                        n_pc  = ramc_pkg::P_FIN;
                    end
                    // Add over the common denominator.
                    ramc_pkg::P_A1: begin
                        n_g = r_ga;
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_db}; div_d = r_ga;
                        step_pc = ramc_pkg::P_A2;
                    end
                    ramc_pkg::P_A2: begin
                        mul_go = 1'b1; mul_a = r_ma; mul_b = r_dq[W-1:0];
                        step_pc = ramc_pkg::P_A3;
                    end
                    ramc_pkg::P_A3: begin
                        n_x = r_p;
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_da}; div_d = r_g;
                        step_pc = ramc_pkg::P_A4;
                    end
                    ramc_pkg::P_A4: begin
                        mul_go = 1'b1; mul_a = r_mb; mul_b = r_dq[W-1:0];
                        step_pc = ramc_pkg::P_A5;
                    end
                    ramc_pkg::P_A5: begin
                        n_x   = add_n;
                        n_neg = add_neg;
                        if (add_n == '0) begin
                            n_neg = 1'b0;
                            n_pc  = ramc_pkg::P_FIN;
                        end else begin
                            div_go = 1'b1; div_n = add_n; div_d = r_g;
                            step_pc = ramc_pkg::P_A6;
                        end
                    end
                    ramc_pkg::P_A6: begin
                        gcd_go = 1'b1; gcd_a = r_rem; gcd_b = r_g;
                        gcd_ret = ramc_pkg::P_A7;
                    end
                    ramc_pkg::P_A7: begin
                        n_g2 = r_ga;
                        div_go = 1'b1; div_n = r_x; div_d = r_ga;
                        step_pc = ramc_pkg::P_A8;
                    end
                    ramc_pkg::P_A8: begin
                        n_rn = r_dq;
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_da}; div_d = r_g2;
                        step_pc = ramc_pkg::P_A9;
                    end
                    ramc_pkg::P_A9: begin
                        n_t1 = r_dq[W-1:0];
                        div_go = 1'b1; div_n = {{W{1'b0}}, r_db}; div_d = r_g;
                        step_pc = ramc_pkg::P_A10;
                    end
                    ramc_pkg::P_A10: begin
                        mul_go = 1'b1; mul_a = r_t1; mul_b = r_dq[W-1:0];
                        step_pc = ramc_pkg::P_A11;
                    end
                    ramc_pkg::P_A11: begin
                        n_rd = r_p;
                        n_pc = ramc_pkg::P_FIN;
                    end
                    // Range check and result word.
                    ramc_pkg::P_FIN: begin
                        n_done  = 1'b1;
                        n_state = ramc_pkg::S_IDLE;
                        n_oless = r_less;
                        n_oovf  = r_ovf | !fits_ok;
                        if (r_ovf || !fits_ok || r_cmd[1]) begin
                            n_onum = '0;
                            n_oden = {{(W-2){1'b0}}, 1'b1};
                        end else begin
                            n_onum = r_neg ? (~r_rn[W-1:0] + 1'b1) : r_rn[W-1:0];
                            n_oden = r_rd[W-2:0];
                        end
                    end
                    default: begin
                        n_state = ramc_pkg::S_IDLE;
                    end
                endcase
            end

            default: begin
                n_state = ramc_pkg::S_IDLE;
            end
        endcase

        // Start a shared unit where a step asked for one.
        if (div_go) begin
            n_dd    = div_d;
            n_rem   = '0;
            n_state = ramc_pkg::S_DIV;
            n_pc    = step_pc;
            if (div_n[WW-1:W] == '0) begin
                n_dq  = {div_n[W-1:0], {W{1'b0}}};
                n_cnt = CB'(W);
            end else begin
                n_dq  = div_n;
                n_cnt = CB'(WW);
            end
        end
        if (mul_go) begin
            n_p     = {{W{1'b0}}, mul_b};
            n_mc    = mul_a;
            n_cnt   = CB'(W);
            n_state = ramc_pkg::S_MUL;
            n_pc    = step_pc;
        end
        if (gcd_go) begin
            n_ga    = gcd_a;
            n_gb    = gcd_b;
            n_gk    = '0;
            n_gret  = gcd_ret;
            n_state = ramc_pkg::S_GCD;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ramc_pkg::S_IDLE;
            r_pc    <= ramc_pkg::P_DEC;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_gret <= n_gret;  r_cnt <= n_cnt;  r_cmd <= n_cmd;
        r_sa <= n_sa;      r_sb <= n_sb;
        r_ma <= n_ma;      r_mb <= n_mb;    r_da <= n_da;    r_db <= n_db;
        r_g <= n_g;        r_g1 <= n_g1;    r_g2 <= n_g2;    r_t1 <= n_t1;
        r_x <= n_x;        r_rn <= n_rn;    r_rd <= n_rd;
        r_neg <= n_neg;    r_less <= n_less; r_ovf <= n_ovf;
        r_dq <= n_dq;      r_dd <= n_dd;    r_rem <= n_rem;
        r_p <= n_p;        r_mc <= n_mc;
        r_ga <= n_ga;      r_gb <= n_gb;    r_gk <= n_gk;
        r_onum <= n_onum;  r_oden <= n_oden;
        r_oless <= n_oless; r_oovf <= n_oovf;
    end

    assign busy         = r_state != ramc_pkg::S_IDLE;
    assign o_done       = r_done;
    assign o_result_num = r_onum;
    assign o_result_den = r_oden;
    assign o_is_less    = r_oless;
    assign o_overflow   = r_oovf;

    // A taken word keeps the unit busy in the next cycle.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after taking a word");

    // The result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // An overflow result is the neutral value.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow) |-> (o_result_num == '0 && o_result_den == 1))
        else $error("overflow result is not zero over one");

    // A compare never flags overflow together with less-than.
    a_less_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_less) |-> (!o_overflow && o_result_num == '0))
        else $error("less-than flag with a non-neutral result");

    // A result denominator is never zero.
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result_den != '0))
        else $error("zero result denominator");

endmodule
